// ===== sv/tsbt_pkg.sv =====
// Shared widths, register indexes and reset values for the touch baseline tracker.
package tsbt_pkg;

	localparam int COUNT_W       = 8;
	localparam int INPUT_SENSORS = 4;
	localparam int SHIFT_W       = 3;
	localparam int ACTIVE_W      = 3;
	localparam int MASK_W        = 4;
	localparam int ACTIVE_MAX    = 7;
	localparam int CFG_IDX_W     = 1;

	typedef logic [COUNT_W-1:0]   count_t;
	typedef logic [SHIFT_W-1:0]   shift_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_TRIP_SHIFT   = 1'b0;
	localparam cfg_idx_t CFG_FILTER_SHIFT = 1'b1;

	localparam shift_t TRIP_SHIFT_RST   = 3'd3;
	localparam shift_t FILTER_SHIFT_RST = 3'd4;

	localparam logic MODE_CAL   = 1'b0;
	localparam logic MODE_SENSE = 1'b1;

	typedef struct packed {
		logic [ACTIVE_W-1:0] active_count;
		logic [MASK_W-1:0]   touched_mask;
		logic                calibrated;
	} result_t;

endpackage

// ===== sv/touch_sensor_baseline_tracker.sv =====
// Capacitive touch baseline tracker: calibration averaging, trip detection, baseline follow.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------------
//   in      | sink      | in_valid / in_ready    | mode, count_a, count_b, count_c, count_d
//   out     | source    | out_valid / out_ready  | active_count, touched_mask, calibrated
//   cfg     | sink      | cfg_valid / cfg_ready  | cfg_index, cfg_data (cfg_ready always 1)
//
// Throughput is one item per cycle unless the consumer stalls; a result is valid once its item
// moves from the input register into the result register.
// The per-sensor baseline update is a feedback loop from the input register back
// into the baseline registers, so each item sees the baselines its predecessor left.
// Reset clears baselines, calibration sums, the step counter and the calibrated flag at once.
// A stalled result holds in the result register; the input register still takes one more
// item, and in_ready drops only while both registers are full and out_ready is low.
module touch_sensor_baseline_tracker #(
	parameter int NUM_SENSORS = 4,
	parameter int CAL_SAMPLES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// scan input
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           mode,
	input  logic [tsbt_pkg::COUNT_W-1:0]   count_a,
	input  logic [tsbt_pkg::COUNT_W-1:0]   count_b,
	input  logic [tsbt_pkg::COUNT_W-1:0]   count_c,
	input  logic [tsbt_pkg::COUNT_W-1:0]   count_d,
	// result output
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tsbt_pkg::ACTIVE_W-1:0]  active_count,
	output logic [tsbt_pkg::MASK_W-1:0]    touched_mask,
	output logic                           calibrated,
	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tsbt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tsbt_pkg::SHIFT_W-1:0]   cfg_data
);

	// Sum of CAL_SAMPLES full-scale counts must fit.
	localparam int SUM_W  = $clog2(CAL_SAMPLES * ((1 << tsbt_pkg::COUNT_W) - 1) + 1);
	localparam int STEP_W = $clog2(CAL_SAMPLES);
	localparam int TC_W   = $clog2(NUM_SENSORS + 1);
	// Divide by CAL_SAMPLES as multiply by a rounded-up reciprocal; exact over the sum range.
	localparam int DIV_SHIFT = SUM_W + $clog2(CAL_SAMPLES);
	localparam int M_W       = SUM_W + 1;
	localparam int PROD_W    = SUM_W + M_W;
	localparam longint RECIP_INT = ((64'd1 << DIV_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES;
	localparam logic [M_W-1:0]    RECIP    = M_W'(RECIP_INT);
	localparam logic [STEP_W-1:0] STEP_END = STEP_W'(CAL_SAMPLES - 1);

	typedef logic [tsbt_pkg::COUNT_W-1:0] count_t;
	typedef logic [SUM_W-1:0]             sum_t;

	// Configuration registers
	tsbt_pkg::shift_t trip_shift_q;
	tsbt_pkg::shift_t filter_shift_q;

	// Input register
	logic   valid_s1;
	logic   mode_s1;
	count_t count_s1 [tsbt_pkg::INPUT_SENSORS];

	// Tracker state
	count_t            baseline_q [NUM_SENSORS];
	sum_t              cal_sum_q  [NUM_SENSORS];
	logic [STEP_W-1:0] cal_step_q;
	logic              cal_done_q;

	// Result register
	logic              out_valid_q;
	tsbt_pkg::result_t result_q;

	// Per-item datapath
	count_t            cnt        [NUM_SENSORS];
	count_t            base_nxt   [NUM_SENSORS];
	sum_t              sum_nxt    [NUM_SENSORS];
	logic [NUM_SENSORS-1:0] trip;
	logic [STEP_W-1:0] step_nxt;
	logic              cal_last;
	logic              done_nxt;
	logic [TC_W-1:0]   trip_cnt;
	logic [tsbt_pkg::MASK_W-1:0]   mask_d;
	logic [tsbt_pkg::ACTIVE_W-1:0] active_d;
	tsbt_pkg::result_t result_d;
	logic              advance;

	// Advance the input register into the result slot when that slot is free or drains.
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Sensors past the physical inputs read a count of zero.
	for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_cnt
		if (g < tsbt_pkg::INPUT_SENSORS) begin : g_real
			assign cnt[g] = count_s1[g];
		end else begin : g_pad
			assign cnt[g] = '0;
		end
	end

	// Mask carries only the physical sensors.
	for (genvar m = 0; m < tsbt_pkg::MASK_W; m++) begin : g_mask
		if (m < NUM_SENSORS) begin : g_used
			assign mask_d[m] = trip[m];
		end else begin : g_unused
			assign mask_d[m] = 1'b0;
		end
	end

	assign cal_last = (mode_s1 == tsbt_pkg::MODE_CAL) && (cal_step_q == STEP_END);
	assign done_nxt = cal_done_q || cal_last;

	assign result_d = '{active_count: active_d, touched_mask: mask_d, calibrated: done_nxt};

	always_comb begin
		logic [tsbt_pkg::COUNT_W-1:0] thr;
		logic [tsbt_pkg::COUNT_W-1:0] avg;
		logic [SUM_W-1:0]             acc;
		logic [PROD_W-1:0]            prod;
		thr  = '0;
		avg  = '0;
		acc  = '0;
		prod = '0;
		trip = '0;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			base_nxt[i] = baseline_q[i];
			sum_nxt[i]  = cal_sum_q[i];
			if (mode_s1 == tsbt_pkg::MODE_CAL) begin
				acc  = cal_sum_q[i] + SUM_W'(cnt[i]);
				prod = PROD_W'(acc) * PROD_W'(RECIP);
				if (cal_last) begin
					base_nxt[i] = prod[DIV_SHIFT +: tsbt_pkg::COUNT_W];
					sum_nxt[i]  = '0;
				end else begin
					sum_nxt[i] = acc;
				end
			end else begin
				// Trip below baseline less its margin; otherwise follow the count.
				thr = baseline_q[i] - (baseline_q[i] >> trip_shift_q);
				avg = baseline_q[i] - (baseline_q[i] >> filter_shift_q)
					+ (cnt[i] >> filter_shift_q);
				if (cnt[i] < thr) begin
					trip[i] = 1'b1;
				end else if (cnt[i] > baseline_q[i]) begin
					base_nxt[i] = cnt[i];
				end else begin
					base_nxt[i] = avg;
				end
			end
		end
	end

	always_comb begin
		step_nxt = cal_step_q;
		if (mode_s1 == tsbt_pkg::MODE_CAL) begin
			step_nxt = cal_last ? '0 : cal_step_q + 1'b1;
		end
	end

	// Count tripped sensors and saturate to the field range.
	always_comb begin
		trip_cnt = '0;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			trip_cnt = trip_cnt + TC_W'(trip[i]);
		end
		if (int'(trip_cnt) > tsbt_pkg::ACTIVE_MAX) begin
			active_d = tsbt_pkg::ACTIVE_W'(tsbt_pkg::ACTIVE_MAX);
		end else begin
			active_d = tsbt_pkg::ACTIVE_W'(trip_cnt);
		end
	end

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trip_shift_q   <= tsbt_pkg::TRIP_SHIFT_RST;
			filter_shift_q <= tsbt_pkg::FILTER_SHIFT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tsbt_pkg::CFG_TRIP_SHIFT:   trip_shift_q   <= cfg_data;
				tsbt_pkg::CFG_FILTER_SHIFT: filter_shift_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1     <= mode;
			count_s1[0] <= count_a;
			count_s1[1] <= count_b;
			count_s1[2] <= count_c;
			count_s1[3] <= count_d;
		end
	end

	// Tracker state, committed as the item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SENSORS; i++) begin
				baseline_q[i] <= '0;
				cal_sum_q[i]  <= '0;
			end
			cal_step_q <= '0;
			cal_done_q <= 1'b0;
		end else if (advance) begin
			for (int i = 0; i < NUM_SENSORS; i++) begin
				baseline_q[i] <= base_nxt[i];
				cal_sum_q[i]  <= sum_nxt[i];
			end
			cal_step_q <= step_nxt;
			cal_done_q <= done_nxt;
		end
	end

	// Result register: hold while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign active_count = result_q.active_count;
	assign touched_mask = result_q.touched_mask;
	assign calibrated   = result_q.calibrated;

endmodule

// ===== sv/tsbt_checker.sv =====
// Port-level checks for the touch baseline tracker, bound to its top level.
module tsbt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [tsbt_pkg::ACTIVE_W-1:0]  active_count,
	input logic [tsbt_pkg::MASK_W-1:0]    touched_mask,
	input logic                           calibrated
);

	// Hold a stalled result.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(active_count)
			&& $stable(touched_mask) && $stable(calibrated))
		else $error("stalled result changed or dropped");

	// Drop input ready only when a result is stuck behind a stalled consumer.
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// Tripped count matches the mask.
	a_count_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> active_count == tsbt_pkg::ACTIVE_W'($countones(touched_mask)))
		else $error("active_count disagrees with touched_mask");

	// Calibrated never falls once delivered.
	a_cal_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && calibrated |=> !out_valid || calibrated)
		else $error("calibrated flag cleared");

endmodule

bind touch_sensor_baseline_tracker tsbt_checker u_tsbt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.active_count (active_count),
	.touched_mask (touched_mask),
	.calibrated   (calibrated)
);
